// ===== src/ocg_pkg.sv =====
// Package for the output command gate: codes, widths, constants and helpers.
package ocg_pkg;

    localparam int unsigned TimeW   = 63;
    localparam int unsigned SpanW   = 40;
    localparam int unsigned IdW     = 16;
    localparam int unsigned NodeW   = 7;
    localparam int unsigned BitsW   = 8;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned InDataW  = 192;
    localparam int unsigned OutDataW = 120;

    localparam logic [SpanW-1:0] TickNs  = SpanW'(10_000_000);
    localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

    typedef enum logic [1:0] {
        OP_COMMAND   = 2'd0,
        OP_HEARTBEAT = 2'd1,
        OP_STATUS    = 2'd2,
        OP_RESTART   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_CMD_STATUS  = 2'd0,
        KIND_HEARTBEAT   = 2'd1,
        KIND_NODE_STATUS = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        RES_APPLIED  = 3'd0,
        RES_SESSION  = 3'd1,
        RES_NOTREADY = 3'd2,
        RES_STALE    = 3'd3,
        RES_EXPIRED  = 3'd4
    } t_result;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_NODE       = 3'd0,
        CFG_READY      = 3'd1,
        CFG_INPUT      = 3'd2,
        CFG_FAULT      = 3'd3,
        CFG_BOOT       = 3'd4,
        CFG_SESSION    = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [1:0]       op;
        logic [IdW-1:0]   sess;
        logic [IdW-1:0]   seq;
        logic [BitsW-1:0] mask;
        logic [BitsW-1:0] vals;
        logic [TimeW-1:0] rx;
        logic [TimeW-1:0] now;
        logic [SpanW-1:0] span;
        logic             expired;
    } t_item;

    function automatic logic [IdW-1:0] nonzero_id(input logic [IdW-1:0] v);
        return (v == '0) ? IdW'(1) : v;
    endfunction

    function automatic logic [IdW-1:0] advance_id(input logic [IdW-1:0] v);
        return (v == {IdW{1'b1}}) ? IdW'(1) : v + IdW'(1);
    endfunction

endpackage

// ===== src/output_command_gate.sv =====
// Output command gate: session, interlock, sequence and deadline checks with masked merge.
//
//  channel  | dir | transfer when              | contents
//  s_axis   | in  | s_axis_tvalid&s_axis_tready| tuser opcode, tdata command fields
//  m_axis   | out | m_axis_tvalid&m_axis_tready| tuser reply kind, tdata reply fields
//  cfg      | in  | i_cfg_we                   | i_cfg_index selects, i_cfg_data value
//
// One item per cycle while no reply waits on m_axis_tready; the stages are span multiply,
// deadline add/compare, and state decision into the output register.
// Each stage moves on when the stage after it is empty or moving, so bubbles
// close up while a reply waits on m_axis_tready.
// Soft restart passes through all stages but produces no reply.
// Synchronous active-low reset loads register defaults and clears the pipeline.
module output_command_gate (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] command_session, [31:16] command_sequence, [47:32] validity_ticks,
    // [55:48] bit_mask, [63:56] bit_values, [126:64] receive_time_ns,
    // [189:127] now_time_ns, rest zero
    input  logic [ocg_pkg::InDataW-1:0]   s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [6:0] reply_node, [22:7] reply_boot, [38:23] reply_session,
    // [54:39] heartbeat_count, [70:55] echo_sequence, [73:71] result_code,
    // [81:74] output_state, [82] ready_echo, [98:83] input_echo,
    // [114:99] fault_echo, rest zero
    output logic [ocg_pkg::OutDataW-1:0]  m_axis_tdata,
    // [1:0] reply_kind
    output logic [1:0]                    m_axis_tuser,
    input  logic                          i_cfg_we,
    input  logic [ocg_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [ocg_pkg::CfgW-1:0]      i_cfg_data
);

    // configuration
    logic [ocg_pkg::NodeW-1:0] r_node;
    logic                      r_ready;
    logic [ocg_pkg::IdW-1:0]   r_input;
    logic [ocg_pkg::IdW-1:0]   r_fault;

    // state
    logic [ocg_pkg::IdW-1:0]   r_boot;
    logic [ocg_pkg::IdW-1:0]   r_session;
    logic [ocg_pkg::IdW-1:0]   r_hb;
    logic [ocg_pkg::BitsW-1:0] r_out_bits;
    logic                      r_have;
    logic [ocg_pkg::IdW-1:0]   r_last_seq;

    // pipeline
    logic                 r_v1, r_v2, r_vout;
    ocg_pkg::t_item       r_s1, r_s2, n_s1, n_s2;
    logic [ocg_pkg::OutDataW-1:0] r_out_data, n_out_data;
    logic [1:0]           r_out_kind, n_out_kind;

    logic rdy_out, rdy2, rdy1, fire2;

    assign rdy_out = !r_vout || m_axis_tready;
    assign rdy2    = !r_v2 || rdy_out;
    assign rdy1    = !r_v1 || rdy2;
    assign fire2   = r_v2 && rdy_out;

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = r_vout;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

    // stage 1: unpack and scale the lifetime
    always_comb begin
        n_s1         = '0;
        n_s1.op      = s_axis_tuser;
        n_s1.sess    = s_axis_tdata[15:0];
        n_s1.seq     = s_axis_tdata[31:16];
        n_s1.mask    = s_axis_tdata[55:48];
        n_s1.vals    = s_axis_tdata[63:56];
        n_s1.rx      = s_axis_tdata[126:64];
        n_s1.now     = s_axis_tdata[189:127];
        n_s1.span    = ocg_pkg::SpanW'(s_axis_tdata[47:32]) * ocg_pkg::TickNs;
        n_s1.expired = 1'b0;
    end

    // stage 2: saturating deadline and expiry
    logic [ocg_pkg::TimeW:0]   dl_sum;
    logic [ocg_pkg::TimeW-1:0] deadline;

    always_comb begin
        dl_sum   = {1'b0, r_s1.rx} + (ocg_pkg::TimeW + 1)'(r_s1.span);
        deadline = dl_sum[ocg_pkg::TimeW] ? ocg_pkg::TimeMax : dl_sum[ocg_pkg::TimeW-1:0];
        n_s2         = r_s1;
        n_s2.expired = (r_s1.now >= deadline);
    end

    // stage 3: decision against state
    logic [ocg_pkg::IdW-1:0]   seq_diff;
    logic                      seq_fresh;
    ocg_pkg::t_result          res;
    logic [ocg_pkg::BitsW-1:0] merged;
    logic [ocg_pkg::BitsW-1:0] mirror;

    always_comb begin
        seq_diff  = r_s2.seq - r_last_seq;
        seq_fresh = (seq_diff != '0) && !seq_diff[ocg_pkg::IdW-1];
        merged    = (r_out_bits & ~r_s2.mask) | (r_s2.vals & r_s2.mask);
        if (r_s2.sess != r_session) begin
            res = ocg_pkg::RES_SESSION;
        end else if (!r_ready) begin
            res = ocg_pkg::RES_NOTREADY;
        end else if (r_have && !seq_fresh) begin
            res = ocg_pkg::RES_STALE;
        end else if (r_s2.expired) begin
            res = ocg_pkg::RES_EXPIRED;
        end else begin
            res = ocg_pkg::RES_APPLIED;
        end
        mirror = (res == ocg_pkg::RES_APPLIED) ? merged : r_out_bits;
    end

    always_comb begin
        n_out_data       = '0;
        n_out_kind       = ocg_pkg::KIND_CMD_STATUS;
        n_out_data[6:0]  = r_node;
        n_out_data[38:23] = r_session;
        case (r_s2.op)
            ocg_pkg::OP_HEARTBEAT: begin
                n_out_kind         = ocg_pkg::KIND_HEARTBEAT;
                n_out_data[22:7]   = r_boot;
                n_out_data[54:39]  = r_hb;
            end
            ocg_pkg::OP_STATUS: begin
                n_out_kind         = ocg_pkg::KIND_NODE_STATUS;
                n_out_data[82]     = r_ready;
                n_out_data[98:83]  = r_input;
                n_out_data[114:99] = r_fault;
            end
            default: begin
                n_out_kind         = ocg_pkg::KIND_CMD_STATUS;
                n_out_data[70:55]  = r_s2.seq;
                n_out_data[73:71]  = res;
                n_out_data[81:74]  = mirror;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_vout <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy_out) begin
                r_vout <= r_v2 && (r_s2.op != ocg_pkg::OP_RESTART);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && s_axis_tvalid) begin
            r_s1 <= n_s1;
        end
        if (rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (fire2) begin
            r_out_data <= n_out_data;
            r_out_kind <= n_out_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node     <= ocg_pkg::NodeW'(1);
            r_ready    <= 1'b0;
            r_input    <= '0;
            r_fault    <= '0;
            r_boot     <= ocg_pkg::IdW'(1);
            r_session  <= ocg_pkg::IdW'(1);
            r_hb       <= '0;
            r_out_bits <= '0;
            r_have     <= 1'b0;
            r_last_seq <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ocg_pkg::CFG_NODE:    r_node    <= i_cfg_data[ocg_pkg::NodeW-1:0];
                ocg_pkg::CFG_READY:   r_ready   <= i_cfg_data[0];
                ocg_pkg::CFG_INPUT:   r_input   <= i_cfg_data;
                ocg_pkg::CFG_FAULT:   r_fault   <= i_cfg_data;
                ocg_pkg::CFG_BOOT:    r_boot    <= ocg_pkg::nonzero_id(i_cfg_data);
                ocg_pkg::CFG_SESSION: r_session <= ocg_pkg::nonzero_id(i_cfg_data);
                default: ;
            endcase
        end else if (fire2) begin
            case (r_s2.op)
                ocg_pkg::OP_RESTART: begin
                    r_boot     <= ocg_pkg::advance_id(r_boot);
                    r_session  <= ocg_pkg::advance_id(r_session);
                    r_hb       <= '0;
                    r_out_bits <= '0;
                    r_have     <= 1'b0;
                    r_last_seq <= '0;
                end
                ocg_pkg::OP_HEARTBEAT: begin
                    r_hb <= r_hb + ocg_pkg::IdW'(1);
                end
                ocg_pkg::OP_COMMAND: begin
                    if (res == ocg_pkg::RES_APPLIED) begin
                        r_out_bits <= merged;
                        r_have     <= 1'b1;
                        r_last_seq <= r_s2.seq;
                    end
                end
                default: ;
            endcase
        end
    end

    a_ids_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_boot != '0) && (r_session != '0))
        else $error("boot or session identifier is zero");

    a_restart_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire2 && r_s2.op == ocg_pkg::OP_RESTART && !i_cfg_we)
        |=> (!r_vout && r_out_bits == '0 && !r_have && r_hb == '0))
        else $error("soft restart left state or produced a reply");

    a_applied_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire2 && r_s2.op == ocg_pkg::OP_COMMAND && res == ocg_pkg::RES_APPLIED
         && !i_cfg_we)
        |=> (r_have && r_last_seq == $past(r_s2.seq) && r_out_data[81:74] == r_out_bits))
        else $error("applied command not recorded");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire2 && r_s2.op == ocg_pkg::OP_COMMAND && res != ocg_pkg::RES_APPLIED
         && !i_cfg_we)
        |=> ($stable(r_out_bits) && $stable(r_last_seq) && $stable(r_have)))
        else $error("rejected command changed state");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_vout))
        else $error("input stalled with an empty stage");

endmodule
